### rtl/pcpa_pkg.sv
package pcpa_pkg;

   // Fixed field widths
   localparam int ADDR_W   = 40;
   localparam int TOP_W    = 41;
   localparam int CPU_W    = 3;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 1;

   // Request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ADDR = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP  = 1'b1;

   // Classified command kinds carried from front end to back end
   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_BAD
   } cmd_kind_type;

   localparam int KIND_W = 2;

   // Back end sequencer
   typedef enum logic {
      BACK_EXEC,
      BACK_POP
   } back_state_type;

endpackage

### rtl/pcpa_front.sv
module pcpa_front import pcpa_pkg::*; #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096,
   parameter int LIST_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
   parameter int PAGE_W     = $clog2(MAX_PAGES),
   parameter int OFF_W      = $clog2(PAGE_BYTES)
) (
   input  logic                            req_op,
   input  logic [CPU_W-1:0]                req_cpu,
   input  logic [ADDR_W-1:0]               req_address,
   input  logic [ADDR_W-1:0]               base_address,
   input  logic [TOP_W-1:0]                top_address,
   output logic [KIND_W+LIST_W+PAGE_W-1:0] cmd_data
);

   localparam int IDX_HI_W = ADDR_W - OFF_W;

   logic [LIST_W-1:0]   cpu_mod;
   logic                aligned;
   logic                ge_base;
   logic                lt_top;
   logic [ADDR_W-1:0]   offset;
   logic [IDX_HI_W-1:0] idx_hi;
   logic                in_range;
   cmd_kind_type        kind;

   // Fold the requesting CPU onto the existing lists
   always_comb begin
      cpu_mod = '0;
      for (int i = 0; i < 8; i++) begin
         if (req_cpu == CPU_W'(i)) begin
            cpu_mod = LIST_W'(i % NUM_CPUS);
         end
      end
   end

   // Address checks for a free
   assign aligned  = (req_address[OFF_W-1:0] == '0);
   assign ge_base  = (req_address >= base_address);
   assign lt_top   = ({1'b0, req_address} < top_address);
   assign offset   = req_address - base_address;
   assign idx_hi   = offset[ADDR_W-1:OFF_W];
   assign in_range = (idx_hi < IDX_HI_W'(MAX_PAGES));

   // Classify
   always_comb begin
      if (req_op == OP_ALLOC) begin
         kind = CMD_ALLOC;
      end else if (aligned && ge_base && lt_top && in_range) begin
         kind = CMD_FREE;
      end else begin
         kind = CMD_BAD;
      end
   end

   assign cmd_data = {kind, cpu_mod, idx_hi[PAGE_W-1:0]};

endmodule

### rtl/pcpa_queue.sv
module pcpa_queue import pcpa_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   output logic             valid,
   input  logic             pop,
   output logic [WIDTH-1:0] data
);

   // Two-entry FIFO between classifier and executor
   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_in;
   logic [1:0]       count_in;

   assign full  = (count_ff == 2'd2);
   assign valid = (count_ff != 2'd0);
   assign data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/pcpa_back.sv
module pcpa_back import pcpa_pkg::*; #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_PAGES  = 32768,
   parameter int LIST_W     = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1,
   parameter int PAGE_W     = $clog2(MAX_PAGES),
   parameter int OFF_W      = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [ADDR_W-1:0]               base_address,
   input  logic                            q_valid,
   input  logic [KIND_W+LIST_W+PAGE_W-1:0] q_data,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [ADDR_W-1:0]               rsp_page_address,
   output logic [CPU_W-1:0]                rsp_source_cpu
);

   // List heads and valid bits
   logic [PAGE_W-1:0]   heads_ff [NUM_CPUS];
   logic [NUM_CPUS-1:0] head_valid_ff;

   // Link memory: {end of list, next page}
   logic [PAGE_W:0]     link_mem [MAX_PAGES];
   logic [PAGE_W:0]     rd_data_ff;

   back_state_type      state_ff, state_in;
   logic [LIST_W-1:0]   tgt_ff, tgt_in;
   logic [PAGE_W-1:0]   page_ff, page_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [CPU_W-1:0]    rsp_src_ff, rsp_src_in;

   cmd_kind_type        cmd_kind;
   logic [LIST_W-1:0]   cmd_cpu;
   logic [PAGE_W-1:0]   cmd_page;
   logic [LIST_W-1:0]   lowest;
   logic                any_valid;
   logic [LIST_W-1:0]   pick;
   logic                start;
   logic                rsp_load;

   logic                mem_we;
   logic [PAGE_W-1:0]   rd_addr;
   logic                list_we;
   logic [LIST_W-1:0]   list_sel;
   logic [PAGE_W-1:0]   list_head_wdata;
   logic                list_valid_wdata;

   logic [PAGE_W+OFF_W-1:0]  page_off;
   logic [LIST_W+CPU_W-1:0]  src_wide;

   assign cmd_kind = cmd_kind_type'(q_data[KIND_W+LIST_W+PAGE_W-1 -: KIND_W]);
   assign cmd_cpu  = q_data[LIST_W+PAGE_W-1 -: LIST_W];
   assign cmd_page = q_data[PAGE_W-1:0];

   // Lowest-numbered nonempty list, used for stealing
   always_comb begin
      lowest = '0;
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
         if (head_valid_ff[i]) begin
            lowest = LIST_W'(i);
         end
      end
   end

   assign any_valid = |head_valid_ff;
   assign pick      = head_valid_ff[cmd_cpu] ? cmd_cpu : lowest;
   assign rd_addr   = heads_ff[pick];

   // A new command starts only with the response slot free or draining
   assign start = (state_ff == BACK_EXEC) && q_valid &&
                  (!rsp_valid_ff || !rsp_stall);

   assign page_off = {page_ff, {OFF_W{1'b0}}};
   assign src_wide = {{CPU_W{1'b0}}, tgt_ff};

   // Sequencer
   always_comb begin
      state_in         = state_ff;
      tgt_in           = tgt_ff;
      page_in          = page_ff;
      q_pop            = 1'b0;
      mem_we           = 1'b0;
      list_we          = 1'b0;
      list_sel         = cmd_cpu;
      list_head_wdata  = cmd_page;
      list_valid_wdata = 1'b1;
      rsp_load         = 1'b0;
      rsp_status_in    = STATUS_OK;
      rsp_page_in      = '0;
      rsp_src_in       = '0;
      case (state_ff)
         BACK_EXEC: begin
            if (start) begin
               q_pop = 1'b1;
               case (cmd_kind)
                  CMD_FREE: begin
                     mem_we   = 1'b1;
                     list_we  = 1'b1;
                     rsp_load = 1'b1;
                  end
                  CMD_ALLOC: begin
                     if (any_valid) begin
                        tgt_in   = pick;
                        page_in  = heads_ff[pick];
                        state_in = BACK_POP;
                     end else begin
                        rsp_load      = 1'b1;
                        rsp_status_in = STATUS_EMPTY;
                     end
                  end
                  default: begin
                     rsp_load      = 1'b1;
                     rsp_status_in = STATUS_BAD_ADDR;
                  end
               endcase
            end
         end
         BACK_POP: begin
            // Link read is back: advance the head or close the list
            list_we          = 1'b1;
            list_sel         = tgt_ff;
            list_head_wdata  = rd_data_ff[PAGE_W-1:0];
            list_valid_wdata = !rd_data_ff[PAGE_W];
            rsp_load         = 1'b1;
            rsp_page_in      = base_address + ADDR_W'(page_off);
            rsp_src_in       = src_wide[CPU_W-1:0];
            state_in         = BACK_EXEC;
         end
         default: begin
            state_in = BACK_EXEC;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_EXEC;
         rsp_valid_ff  <= 1'b0;
         head_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (list_we) begin
            head_valid_ff[list_sel] <= list_valid_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tgt_ff  <= tgt_in;
      page_ff <= page_in;
      if (list_we) begin
         heads_ff[list_sel] <= list_head_wdata;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_page_ff   <= rsp_page_in;
         rsp_src_ff    <= rsp_src_in;
      end
   end

   // Link memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[cmd_page] <= {!head_valid_ff[cmd_cpu], heads_ff[cmd_cpu]};
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_ff;
   assign rsp_source_cpu   = rsp_src_ff;

endmodule

### rtl/per_cpu_page_free_list_allocator.sv
// Page allocator with one LIFO free list per CPU, threaded through a
// next-page link memory of MAX_PAGES entries. A free pushes a checked page
// onto the requesting CPU's list (status 2 if misaligned, outside
// [base_address, top_address) or beyond the link memory); an allocate pops
// from the CPU's own list, otherwise from the lowest-numbered nonempty
// list, and reports status 1 when every list is empty. Lists are empty
// after reset; the link memory is not cleared and needs no init time.
// A front stage classifies each request in its accept cycle and hands it
// through a two-entry queue to the executor. The executor finishes a free,
// a rejected request or an allocate that finds every list empty in
// BACK_EXEC; an allocate that finds a page does head select and link memory
// read in BACK_EXEC, then head update in BACK_POP, as the link memory read
// is registered. PAGE_BYTES must be a power of two.
module per_cpu_page_free_list_allocator import pcpa_pkg::*; #(
   parameter int NUM_CPUS   = 8,
   parameter int MAX_PAGES  = 32768,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [CPU_W-1:0]     req_cpu,
   input  logic [ADDR_W-1:0]    req_address,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [ADDR_W-1:0]    rsp_page_address,
   output logic [CPU_W-1:0]     rsp_source_cpu,
   // register writes
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TOP_W-1:0]     csr_write_data
);

   localparam int LIST_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int PAGE_W = $clog2(MAX_PAGES);
   localparam int OFF_W  = $clog2(PAGE_BYTES);
   localparam int CMD_W  = KIND_W + LIST_W + PAGE_W;

   logic [ADDR_W-1:0] base_ff;
   logic [TOP_W-1:0]  top_ff;
   logic [CMD_W-1:0]  cmd_data;
   logic [CMD_W-1:0]  q_data;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;
   logic              req_xfer;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= ADDR_W'(64'h0080000000);
         top_ff  <= TOP_W'(64'h0088000000);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BASE: base_ff <= csr_write_data[ADDR_W-1:0];
            CSR_TOP:  top_ff  <= csr_write_data;
            default:  ;
         endcase
      end
   end

   assign req_stall = q_full;
   assign req_xfer  = req_valid && !q_full;

   pcpa_front #(
      .NUM_CPUS   (NUM_CPUS),
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES),
      .LIST_W     (LIST_W),
      .PAGE_W     (PAGE_W),
      .OFF_W      (OFF_W)
   ) u_front (
      .req_op       (req_op),
      .req_cpu      (req_cpu),
      .req_address  (req_address),
      .base_address (base_ff),
      .top_address  (top_ff),
      .cmd_data     (cmd_data)
   );

   pcpa_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_data (cmd_data),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .data      (q_data)
   );

   pcpa_back #(
      .NUM_CPUS  (NUM_CPUS),
      .MAX_PAGES (MAX_PAGES),
      .LIST_W    (LIST_W),
      .PAGE_W    (PAGE_W),
      .OFF_W     (OFF_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .base_address     (base_ff),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_source_cpu   (rsp_source_cpu)
   );

`ifndef ASSERT_OFF
   // No response survives a reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Only defined status codes leave the block
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STATUS_OK || rsp_status == STATUS_EMPTY ||
                     rsp_status == STATUS_BAD_ADDR))
      else $error("undefined response status");

   // Failed requests carry no page
   a_fail_no_page: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |->
         (rsp_page_address == '0 && rsp_source_cpu == '0))
      else $error("failed response carries a page");
`endif

endmodule

### sim/tb_per_cpu_page_free_list_allocator.sv
module tb_per_cpu_page_free_list_allocator import pcpa_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CPUS       = 8;
   localparam int MAX_PAGES      = 32768;
   localparam int PAGE_BYTES     = 4096;
   localparam int PAGE_SHIFT     = 12;
   localparam int IDX_W          = $clog2(MAX_PAGES);
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 228;
   localparam int PRESSURE_PHASE = 4;
   localparam int PROBE_COUNT    = 24;

   // one response transfer
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   page;
      logic [CPU_W-1:0]    src;
   } page_result_type;

   // directed row: request plus optional hand-typed response
   typedef struct packed {
      logic            op;
      logic [CPU_W-1:0]  cpu;
      logic [ADDR_W-1:0] addr;
      logic            typed;
      page_result_type want;
   } probe_row_type;

   localparam page_result_type R_OK    = '{STATUS_OK, '0, '0};
   localparam page_result_type R_EMPTY = '{STATUS_EMPTY, '0, '0};
   localparam page_result_type R_BAD   = '{STATUS_BAD_ADDR, '0, '0};

   // reset config: base 0x8000_0000, top 0x8800_0000
   localparam probe_row_type PROBES [PROBE_COUNT] = '{
      '{OP_ALLOC, 3'd0, 40'hFF_FFFF_FFFF, 1'b1, R_EMPTY},  // nothing freed yet
      '{OP_FREE,  3'd0, 40'h00_0000_0000, 1'b1, R_BAD},    // below base
      '{OP_FREE,  3'd0, 40'h00_8000_0800, 1'b1, R_BAD},    // misaligned
      '{OP_FREE,  3'd0, 40'h00_8800_0000, 1'b1, R_BAD},    // at top
      '{OP_FREE,  3'd7, 40'hFF_FFFF_FFFF, 1'b1, R_BAD},    // all ones
      '{OP_FREE,  3'd7, 40'h00_7FFF_F000, 1'b1, R_BAD},    // page just below base
      '{OP_FREE,  3'd3, 40'h00_8000_0000, 1'b1, R_OK},     // first page
      '{OP_FREE,  3'd3, 40'h00_87FF_F000, 1'b1, R_OK},     // last page
      '{OP_ALLOC, 3'd3, 40'h00_0000_0000, 1'b0, R_OK},     // own list, LIFO
      '{OP_ALLOC, 3'd6, 40'h00_0000_0000, 1'b0, R_OK},     // steal from cpu 3
      '{OP_ALLOC, 3'd6, 40'h00_0000_0000, 1'b1, R_EMPTY},
      '{OP_FREE,  3'd0, 40'h00_8000_1000, 1'b1, R_OK},
      '{OP_FREE,  3'd7, 40'h00_8000_2000, 1'b1, R_OK},
      '{OP_ALLOC, 3'd5, 40'h00_0000_0000, 1'b0, R_OK},     // lowest donor first
      '{OP_ALLOC, 3'd5, 40'h00_0000_0000, 1'b0, R_OK},
      '{OP_FREE,  3'd2, 40'h00_8000_3000, 1'b1, R_OK},
      '{OP_FREE,  3'd4, 40'h00_8000_3000, 1'b1, R_OK},     // same page on two lists
      '{OP_ALLOC, 3'd2, 40'h00_0000_0000, 1'b0, R_OK},
      '{OP_ALLOC, 3'd4, 40'h00_0000_0000, 1'b0, R_OK},
      '{OP_ALLOC, 3'd1, 40'hFF_FFFF_FFFF, 1'b1, R_EMPTY},
      '{OP_FREE,  3'd1, 40'h00_8000_4000, 1'b1, R_OK},
      '{OP_FREE,  3'd1, 40'h00_8000_5000, 1'b1, R_OK},
      '{OP_ALLOC, 3'd1, 40'h00_0000_0000, 1'b0, R_OK},
      '{OP_ALLOC, 3'd1, 40'h00_0000_0000, 1'b0, R_OK}
   };

   // register settings and idle mix per random phase
   localparam logic [ADDR_W-1:0] PHASE_BASE [PHASE_COUNT] = '{
      40'h00_8000_0000, 40'h00_0000_0000, 40'h12_3456_789A, 40'hFF_FFFF_F000,
      40'h00_0000_0000, 40'h00_0000_1000, 40'h00_4000_0000, 40'h00_8000_0000
   };
   localparam logic [TOP_W-1:0] PHASE_TOP [PHASE_COUNT] = '{
      41'h000_8800_0000, 41'h100_0000_0000, 41'h012_3856_789A, 41'h1FF_FFFF_FFFF,
      41'h000_0000_0000, 41'h000_0000_1000, 41'h000_4010_0000, 41'h000_8800_0000
   };
   localparam int PHASE_SEND_IDLE [PHASE_COUNT] = '{0, 81, 0, 34, 0, 81, 0, 34};
   localparam int PHASE_RECV_STALL [PHASE_COUNT] = '{0, 0, 81, 34, 0, 0, 81, 34};

   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_op           = OP_ALLOC;
   logic [CPU_W-1:0]     req_cpu          = '0;
   logic [ADDR_W-1:0]    req_address      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [ADDR_W-1:0]    rsp_page_address;
   logic [CPU_W-1:0]     rsp_source_cpu;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = CSR_BASE;
   logic [TOP_W-1:0]     csr_write_data   = '0;

   // allocator state as predicted
   logic [ADDR_W-1:0] base_q = 40'h00_8000_0000;
   logic [TOP_W-1:0]  top_q  = 41'h000_8800_0000;
   logic [IDX_W-1:0]  head_page [NUM_CPUS];
   bit                head_live [NUM_CPUS];
   logic [IDX_W-1:0]  link_page [MAX_PAGES];
   bit                link_last [MAX_PAGES];

   // pending responses, and the software view used to pick addresses
   page_result_type   pending_q [$];
   logic [ADDR_W-1:0] held_pages [$];
   bit                page_listed [MAX_PAGES];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int phase_id       = -1;
   int hold_left      = 0;
   bit pressure_done  = 1'b0;
   int cycle_count    = 0;
   int error_count    = 0;
   int n_alloc = 0, n_stolen = 0, n_empty = 0, n_freed = 0, n_rejected = 0;

   per_cpu_page_free_list_allocator #(
      .NUM_CPUS   (NUM_CPUS),
      .MAX_PAGES  (MAX_PAGES),
      .PAGE_BYTES (PAGE_BYTES)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_cpu          (req_cpu),
      .req_address      (req_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_source_cpu   (rsp_source_cpu),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_q.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // pop the head of one list
   function automatic bit take_page(input int c, output logic [IDX_W-1:0] pg);
      if (!head_live[c])
         return 1'b0;
      pg = head_page[c];
      if (link_last[pg]) begin
         head_live[c] = 1'b0;
         head_page[c] = '0;
      end else begin
         head_page[c] = link_page[pg];
      end
      return 1'b1;
   endfunction

   // expected response of one request; updates the predicted lists
   function automatic page_result_type predict_request(input logic op,
                                                       input logic [CPU_W-1:0] cpu,
                                                       input logic [ADDR_W-1:0] addr);
      page_result_type   res;
      logic [ADDR_W-1:0] offset;
      logic [IDX_W-1:0]  pg;
      int                c;
      int                from;
      bit                got;
      res = '0;
      c = int'(cpu) % NUM_CPUS;
      if (op == OP_FREE) begin
         offset = addr - base_q;
         if (addr % PAGE_BYTES != 0 || addr < base_q || {1'b0, addr} >= top_q ||
             offset / PAGE_BYTES >= MAX_PAGES) begin
            res.status = STATUS_BAD_ADDR;
         end else begin
            // push; the old head becomes the link
            pg = IDX_W'(offset / PAGE_BYTES);
            link_last[pg] = !head_live[c];
            link_page[pg] = head_live[c] ? head_page[c] : '0;
            head_page[c] = pg;
            head_live[c] = 1'b1;
         end
      end else begin
         from = c;
         got = take_page(c, pg);
         // steal from the lowest-numbered other list
         for (int i = 0; i < NUM_CPUS && !got; i++) begin
            if (i != c && take_page(i, pg)) begin
               got = 1'b1;
               from = i;
            end
         end
         if (got) begin
            res.page = base_q + ADDR_W'(pg) * ADDR_W'(PAGE_BYTES);
            res.src  = CPU_W'(from);
         end else begin
            res.status = STATUS_EMPTY;
         end
      end
      return res;
   endfunction

   // offer one request, wait for its transfer, record the expectation
   task automatic send_request(input logic op, input logic [CPU_W-1:0] cpu,
                               input logic [ADDR_W-1:0] addr, input logic typed,
                               input page_result_type want);
      page_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_cpu     <= cpu;
      req_address <= addr;
      do @(posedge clock); while (req_stall);
      res = predict_request(op, cpu, addr);
      pending_q.push_back(typed ? want : res);
      // track what software holds and what sits on lists
      if (op == OP_FREE) begin
         if (res.status == STATUS_OK) begin
            n_freed++;
            page_listed[IDX_W'((addr - base_q) >> PAGE_SHIFT)] = 1'b1;
         end else begin
            n_rejected++;
         end
      end else begin
         n_alloc++;
         if (res.status == STATUS_OK) begin
            page_listed[IDX_W'((res.page - base_q) >> PAGE_SHIFT)] = 1'b0;
            held_pages.push_back(res.page);
            if (res.src != cpu)
               n_stolen++;
         end else begin
            n_empty++;
         end
      end
   endtask

   // mostly frees of held pages and allocations, some fresh and bad frees
   task automatic random_request();
      logic [CPU_W-1:0]  cpu;
      logic [ADDR_W-1:0] first;
      logic [ADDR_W-1:0] addr;
      logic              op;
      int                roll;
      int                k;
      cpu   = CPU_W'($urandom_range(NUM_CPUS - 1));
      roll  = $urandom_range(99);
      op    = OP_FREE;
      first = (base_q + ADDR_W'(PAGE_BYTES - 1)) & ~ADDR_W'(PAGE_BYTES - 1);
      k     = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAGES - 1) : $urandom_range(47);
      if (roll < 45) begin
         op   = OP_ALLOC;
         addr = ADDR_W'({$urandom(), $urandom()});
      end else if (roll < 75 && held_pages.size() > 0) begin
         k    = $urandom_range(held_pages.size() - 1);
         addr = held_pages[k];
         held_pages.delete(k);
      end else if (roll < 88) begin
         addr = first + ADDR_W'(k) * ADDR_W'(PAGE_BYTES);
         // a page already listed is freed again only now and then
         if (page_listed[IDX_W'((addr - base_q) >> PAGE_SHIFT)] && $urandom_range(99) >= 3)
            op = OP_ALLOC;
      end else begin
         case ($urandom_range(6))
            0: addr = first + ADDR_W'(k) * ADDR_W'(PAGE_BYTES) +
                      ADDR_W'($urandom_range(PAGE_BYTES - 1, 1));
            1: addr = ADDR_W'({$urandom(), $urandom()});
            2: addr = top_q[ADDR_W-1:0] & ~ADDR_W'(PAGE_BYTES - 1);
            3: addr = first - ADDR_W'(PAGE_BYTES);
            4: addr = first + ADDR_W'(MAX_PAGES) * ADDR_W'(PAGE_BYTES);
            5: addr = '0;
            default: addr = '1;
         endcase
      end
      send_request(op, cpu, addr, 1'b0, R_OK);
   endtask

   // let the block go idle before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [ADDR_W-1:0] new_base,
                            input logic [TOP_W-1:0] new_top);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BASE;
      csr_write_data   <= TOP_W'(new_base);
      @(posedge clock);
      csr_index        <= CSR_TOP;
      csr_write_data   <= new_top;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      base_q = new_base;
      top_q  = new_top;
   endtask

   // response checker and stall generator
   always @(posedge clock) begin : rsp_side
      page_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response status %0d page %h cpu %0d", $time,
                     rsp_status, rsp_page_address, rsp_source_cpu);
         end else begin
            want = pending_q.pop_front();
            if (rsp_status !== want.status) begin
               error_count++;
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
            end
            if (rsp_page_address !== want.page) begin
               error_count++;
               $display("%0t: page_address expected %h got %h", $time, want.page,
                        rsp_page_address);
            end
            if (rsp_source_cpu !== want.src) begin
               error_count++;
               $display("%0t: source_cpu expected %0d got %0d", $time, want.src,
                        rsp_source_cpu);
            end
         end
      end
      // one long hold-off so the request side backs up
      if (phase_id == PRESSURE_PHASE && !pressure_done) begin
         hold_left     = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests at reset config, no idling
      for (int i = 0; i < PROBE_COUNT; i++)
         send_request(PROBES[i].op, PROBES[i].cpu, PROBES[i].addr, PROBES[i].typed,
                      PROBES[i].want);

      // random phases, lists carry over between register settings
      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         settle();
         send_idle_pct  = PHASE_SEND_IDLE[ph];
         recv_stall_pct = PHASE_RECV_STALL[ph];
         configure(PHASE_BASE[ph], PHASE_TOP[ph]);
         phase_id = ph;
         repeat (PHASE_ITEMS) random_request();
      end

      recv_stall_pct = 0;
      settle();
      $display("Requests: %0d allocations (%0d stolen, %0d on empty lists),",
               n_alloc, n_stolen, n_empty);
      $display("  %0d frees, %0d rejected, over reset plus %0d register settings",
               n_freed, n_rejected, PHASE_COUNT);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
rtl/pcpa_pkg.sv
rtl/pcpa_front.sv
rtl/pcpa_queue.sv
rtl/pcpa_back.sv
rtl/per_cpu_page_free_list_allocator.sv
sim/tb_per_cpu_page_free_list_allocator.sv
